[hdl/sgec_pkg.sv]
// Shared types, constants and record tables for the grid connectivity block.
package sgec_pkg;

   // Grid limits and field widths
   localparam int MAX_NODES_PER_AXIS = 1024;
   localparam int AXIS_W   = 11;   // node count per axis
   localparam int CIDX_W   = 10;   // cell index per axis
   localparam int NXY_W    = 21;   // nodes in one layer
   localparam int CELL_W   = 30;   // linear cell number
   localparam int NODE_W   = 31;   // node number
   localparam int ORD_W    = 35;   // record ordinal
   localparam int STEP_W   = 5;    // record counter within one cell
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_TYPE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_FACES   = 3'd4;

   // Element type codes
   localparam logic [2:0] ET_QUAD    = 3'd0;
   localparam logic [2:0] ET_TRI_ALT = 3'd1;
   localparam logic [2:0] ET_TRI_UNI = 3'd2;
   localparam logic [2:0] ET_TET     = 3'd3;
   localparam logic [2:0] ET_HEX     = 3'd4;

   // Record step counts (last step index)
   localparam logic [STEP_W-1:0] LAST_SINGLE   = 5'd0;
   localparam logic [STEP_W-1:0] LAST_TRI      = 5'd1;
   localparam logic [STEP_W-1:0] LAST_TET      = 5'd4;
   localparam logic [STEP_W-1:0] LAST_TET_FACE = 5'd24;
   localparam logic [STEP_W-1:0] LAST_HEX_FACE = 5'd6;
   localparam logic [STEP_W-1:0] TET_VOLS      = 5'd5;

   // Cell class decided by the front end
   typedef enum logic [2:0] {
      MODE_BAD,
      MODE_QUAD,
      MODE_TRI_SPLIT,   // diagonal from second to fourth corner
      MODE_TRI_CROSS,   // diagonal from first to third corner
      MODE_TET,
      MODE_HEX
   } mode_type;

   // Tetrahedra of a cell, corners 0..3 bottom, 4..7 top
   localparam logic [2:0] TET_VOL [5][4] = '{
      '{3'd0, 3'd1, 3'd3, 3'd4},
      '{3'd1, 3'd2, 3'd3, 3'd6},
      '{3'd4, 3'd3, 3'd7, 3'd6},
      '{3'd4, 3'd1, 3'd6, 3'd5},
      '{3'd3, 3'd1, 3'd4, 3'd6}
   };

   // Faces of one tetrahedron: abc, abd, bcd, acd
   localparam logic [1:0] TET_FACE [4][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd0, 2'd1, 2'd3},
      '{2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3}
   };

   // Faces of a hexahedron
   localparam logic [2:0] HEX_FACE [6][4] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3},
      '{3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd1, 3'd5, 3'd6, 3'd2},
      '{3'd0, 3'd4, 3'd7, 3'd3},
      '{3'd0, 3'd1, 3'd5, 3'd4},
      '{3'd3, 3'd2, 3'd6, 3'd7}
   };

   // Channel payloads
   typedef struct packed {
      logic [CIDX_W-1:0] cell_x;
      logic [CIDX_W-1:0] cell_y;
      logic [CIDX_W-1:0] cell_z;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [ORD_W-1:0]  ordinal;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_c;
      logic [NODE_W-1:0] node_d;
      logic [NODE_W-1:0] node_e;
      logic [NODE_W-1:0] node_f;
      logic [NODE_W-1:0] node_g;
      logic [NODE_W-1:0] node_h;
      logic              bad_cell;
      logic              last;
   } rsp_type;

   // Register file contents
   typedef struct packed {
      logic [AXIS_W-1:0] nodes_x;
      logic [AXIS_W-1:0] nodes_y;
      logic [AXIS_W-1:0] nodes_z;
      logic [2:0]        element_type;
      logic              emit_faces;
   } cfg_type;

   // One classified cell, queued between front and back
   typedef struct packed {
      mode_type                 mode;
      logic [STEP_W-1:0]        last_step;
      logic [ORD_W-1:0]         ord_vol;
      logic [ORD_W-1:0]         ord_surf;
      logic [7:0][NODE_W-1:0]   corner;
   } entry_type;

   // Per-record selection
   typedef struct packed {
      logic              kind;
      logic              bad;
      logic              use_d;
      logic              use_hi;
      logic [STEP_W-1:0] offset;
      logic [3:0][2:0]   idx;
   } rec_type;

   function automatic logic [AXIS_W-1:0] clamp_nodes(input logic [AXIS_W-1:0] n);
      logic [AXIS_W-1:0] lim;
      lim = AXIS_W'(MAX_NODES_PER_AXIS);
      return (n > lim) ? lim : n;
   endfunction

   // Corner selection, kind and ordinal offset of record 'step' of a cell
   function automatic rec_type record_decode(input mode_type mode,
                                             input logic [STEP_W-1:0] step);
      rec_type           r;
      logic [STEP_W-1:0] j;
      logic [2:0]        ti;
      logic [1:0]        tf;
      logic [2:0]        hf;
      r  = '0;
      j  = step - TET_VOLS;
      ti = j[4:2];
      tf = j[1:0];
      hf = 3'(step - 5'd1);
      case (mode)
         MODE_BAD: begin
            r.bad = 1'b1;
         end
         MODE_QUAD: begin
            r.use_d = 1'b1;
            r.idx[0] = 3'd0; r.idx[1] = 3'd1; r.idx[2] = 3'd2; r.idx[3] = 3'd3;
         end
         MODE_TRI_SPLIT: begin
            r.offset = step;
            if (step == 5'd0) begin
               r.idx[0] = 3'd0; r.idx[1] = 3'd1; r.idx[2] = 3'd3;
            end else begin
               r.idx[0] = 3'd1; r.idx[1] = 3'd2; r.idx[2] = 3'd3;
            end
         end
         MODE_TRI_CROSS: begin
            r.offset = step;
            if (step == 5'd0) begin
               r.idx[0] = 3'd0; r.idx[1] = 3'd1; r.idx[2] = 3'd2;
            end else begin
               r.idx[0] = 3'd0; r.idx[1] = 3'd2; r.idx[2] = 3'd3;
            end
         end
         MODE_TET: begin
            if (step < TET_VOLS) begin
               r.kind   = 1'b1;
               r.use_d  = 1'b1;
               r.offset = step;
               for (int k = 0; k < 4; k++) r.idx[k] = TET_VOL[step[2:0]][k];
            end else begin
               r.offset = j;
               for (int k = 0; k < 3; k++) r.idx[k] = TET_VOL[ti][TET_FACE[tf][k]];
            end
         end
         MODE_HEX: begin
            r.use_d = 1'b1;
            if (step == 5'd0) begin
               r.kind   = 1'b1;
               r.use_hi = 1'b1;
               r.idx[0] = 3'd0; r.idx[1] = 3'd1; r.idx[2] = 3'd2; r.idx[3] = 3'd3;
            end else begin
               r.offset = step - 5'd1;
               for (int k = 0; k < 4; k++) r.idx[k] = HEX_FACE[hf][k];
            end
         end
         default: begin
            r.bad = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

[hdl/sgec_front.sv]
// Front end: accepts cells, checks them against the grid and computes node bases.
module sgec_front (
   input  logic                clock,
   input  logic                reset,
   input  sgec_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  sgec_pkg::req_type   req_data,
   input  logic                q_full,
   output logic                q_push,
   output sgec_pkg::entry_type q_entry
);

   // Stage handshake
   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic ready_a, ready_b, ready_c, ready_d;

   assign ready_d   = !vd_ff || !q_full;
   assign ready_c   = !vc_ff || ready_d;
   assign ready_b   = !vb_ff || ready_c;
   assign ready_a   = !va_ff || ready_b;
   assign req_stall = !ready_a;
   assign q_push    = vd_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (ready_a) va_ff <= req_valid;
         if (ready_b) vb_ff <= va_ff;
         if (ready_c) vc_ff <= vb_ff;
         if (ready_d) vd_ff <= vc_ff;
      end
   end

   // Stage A: classify, first products
   logic [sgec_pkg::AXIS_W-1:0] nxc, nyc, nzc, nym1;
   logic [sgec_pkg::CIDX_W-1:0] x, y, z, zm1, ym1;
   logic                        vol, bad, odd;
   sgec_pkg::mode_type          mode;

   assign nxc  = sgec_pkg::clamp_nodes(cfg.nodes_x);
   assign nyc  = sgec_pkg::clamp_nodes(cfg.nodes_y);
   assign nzc  = sgec_pkg::clamp_nodes(cfg.nodes_z);
   assign nym1 = nyc - 11'd1;
   assign x    = req_data.cell_x;
   assign y    = req_data.cell_y;
   assign z    = req_data.cell_z;
   assign vol  = (cfg.element_type == sgec_pkg::ET_TET) ||
                 (cfg.element_type == sgec_pkg::ET_HEX);
   assign zm1  = vol ? (z - 10'd1) : '0;
   assign ym1  = y - 10'd1;
   assign odd  = x[0] ^ y[0];

   always_comb begin
      bad = 1'b0;
      if (cfg.element_type > sgec_pkg::ET_HEX) bad = 1'b1;
      if (x == '0 || {1'b0, x} >= nxc) bad = 1'b1;
      if (y == '0 || {1'b0, y} >= nyc) bad = 1'b1;
      if (vol && (z == '0 || {1'b0, z} >= nzc)) bad = 1'b1;
   end

   always_comb begin
      case (cfg.element_type)
         sgec_pkg::ET_QUAD:    mode = sgec_pkg::MODE_QUAD;
         sgec_pkg::ET_TRI_ALT: mode = odd ? sgec_pkg::MODE_TRI_SPLIT
                                          : sgec_pkg::MODE_TRI_CROSS;
         sgec_pkg::ET_TRI_UNI: mode = sgec_pkg::MODE_TRI_SPLIT;
         sgec_pkg::ET_TET:     mode = sgec_pkg::MODE_TET;
         sgec_pkg::ET_HEX:     mode = sgec_pkg::MODE_HEX;
         default:              mode = sgec_pkg::MODE_BAD;
      endcase
      if (bad) mode = sgec_pkg::MODE_BAD;
   end

   sgec_pkg::mode_type           a_mode_ff;
   logic                         a_faces_ff;
   logic [sgec_pkg::CIDX_W-1:0]  a_x_ff, a_ym1_ff, a_zm1_ff;
   logic [sgec_pkg::AXIS_W-1:0]  a_nx_ff;
   logic [19:0]                  a_p1_ff;
   logic [sgec_pkg::NXY_W-1:0]   a_p2_ff, a_nxy_ff;

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_mode_ff  <= mode;
         a_faces_ff <= cfg.emit_faces;
         a_x_ff     <= x;
         a_ym1_ff   <= ym1;
         a_zm1_ff   <= zm1;
         a_nx_ff    <= nxc;
         a_p1_ff    <= {10'd0, zm1} * {10'd0, nym1[9:0]};
         a_p2_ff    <= {11'd0, ym1} * {10'd0, nxc};
         a_nxy_ff   <= {10'd0, nxc} * {10'd0, nyc};
      end
   end

   // Stage B: row sums and layer offset
   sgec_pkg::mode_type           b_mode_ff;
   logic                         b_faces_ff;
   logic [sgec_pkg::CIDX_W-1:0]  b_x_ff;
   logic [sgec_pkg::AXIS_W-1:0]  b_nx_ff;
   logic [sgec_pkg::NXY_W-1:0]   b_nxy_ff, b_s_ff;
   logic [19:0]                  b_c1_ff;
   logic [sgec_pkg::NODE_W-1:0]  b_q_ff;

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_mode_ff  <= a_mode_ff;
         b_faces_ff <= a_faces_ff;
         b_x_ff     <= a_x_ff;
         b_nx_ff    <= a_nx_ff;
         b_nxy_ff   <= a_nxy_ff;
         b_c1_ff    <= a_p1_ff + {10'd0, a_ym1_ff};
         b_s_ff     <= a_p2_ff + {11'd0, a_x_ff};
         b_q_ff     <= {21'd0, a_zm1_ff} * {10'd0, a_nxy_ff};
      end
   end

   // Stage C: cell number and base node
   logic [sgec_pkg::CIDX_W-1:0]  nxm1;
   sgec_pkg::mode_type           c_mode_ff;
   logic                         c_faces_ff;
   logic [sgec_pkg::AXIS_W-1:0]  c_nx_ff;
   logic [sgec_pkg::NXY_W-1:0]   c_nxy_ff;
   logic [sgec_pkg::CELL_W-1:0]  c_cell_ff;
   logic [sgec_pkg::NODE_W-1:0]  c_k0_ff;

   assign nxm1 = 10'(b_nx_ff - 11'd1);

   always_ff @(posedge clock) begin
      if (ready_c) begin
         c_mode_ff  <= b_mode_ff;
         c_faces_ff <= b_faces_ff;
         c_nx_ff    <= b_nx_ff;
         c_nxy_ff   <= b_nxy_ff;
         c_cell_ff  <= ({10'd0, b_c1_ff} * {20'd0, nxm1}) + {20'd0, b_x_ff};
         c_k0_ff    <= b_q_ff + {10'd0, b_s_ff};
      end
   end

   // Stage D: corners, ordinal bases, record count
   logic [sgec_pkg::ORD_W-1:0]   cell_e, cm1;
   logic [sgec_pkg::NODE_W-1:0]  nx_e, nxy_e, k_top;
   logic [sgec_pkg::ORD_W-1:0]   ord_vol, ord_surf;
   logic [sgec_pkg::STEP_W-1:0]  last_step;
   sgec_pkg::entry_type          d_entry_ff;

   assign cell_e = {5'd0, c_cell_ff};
   assign cm1    = cell_e - 35'd1;
   assign nx_e   = {20'd0, c_nx_ff};
   assign nxy_e  = {10'd0, c_nxy_ff};
   assign k_top  = c_k0_ff + nxy_e;

   always_comb begin
      ord_vol   = cell_e;
      ord_surf  = cell_e;
      last_step = sgec_pkg::LAST_SINGLE;
      case (c_mode_ff)
         sgec_pkg::MODE_TRI_SPLIT, sgec_pkg::MODE_TRI_CROSS: begin
            ord_surf  = (cm1 << 1) + 35'd1;
            last_step = sgec_pkg::LAST_TRI;
         end
         sgec_pkg::MODE_TET: begin
            ord_vol   = (cm1 << 2) + cm1 + 35'd1;
            ord_surf  = (cm1 << 4) + (cm1 << 2) + 35'd1;
            last_step = c_faces_ff ? sgec_pkg::LAST_TET_FACE : sgec_pkg::LAST_TET;
         end
         sgec_pkg::MODE_HEX: begin
            ord_surf  = (cm1 << 2) + (cm1 << 1) + 35'd1;
            last_step = c_faces_ff ? sgec_pkg::LAST_HEX_FACE : sgec_pkg::LAST_SINGLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready_d) begin
         d_entry_ff.mode      <= c_mode_ff;
         d_entry_ff.last_step <= last_step;
         d_entry_ff.ord_vol   <= ord_vol;
         d_entry_ff.ord_surf  <= ord_surf;
         d_entry_ff.corner[0] <= c_k0_ff;
         d_entry_ff.corner[1] <= c_k0_ff + 31'd1;
         d_entry_ff.corner[2] <= c_k0_ff + nx_e + 31'd1;
         d_entry_ff.corner[3] <= c_k0_ff + nx_e;
         d_entry_ff.corner[4] <= k_top;
         d_entry_ff.corner[5] <= k_top + 31'd1;
         d_entry_ff.corner[6] <= k_top + nx_e + 31'd1;
         d_entry_ff.corner[7] <= k_top + nx_e;
      end
   end

   assign q_entry = d_entry_ff;

endmodule

[hdl/sgec_queue.sv]
// Four-entry queue of classified cells between front and back end.
module sgec_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sgec_pkg::entry_type push_entry,
   input  logic                pop,
   output sgec_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   sgec_pkg::entry_type slot_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   assign full  = count_ff == 3'd4;
   assign empty = count_ff == 3'd0;
   assign head  = slot_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 3'd1;
            2'b01:   count_ff <= count_ff - 3'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[hdl/sgec_back.sv]
// Back end: steps through the records of the queued cell, one per cycle while rsp_stall is low.
module sgec_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  sgec_pkg::entry_type head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sgec_pkg::rsp_type   rsp_data
);

   logic [sgec_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sgec_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   sgec_pkg::rec_type           rec;
   logic                        advance, fire, is_last;
   logic [sgec_pkg::ORD_W-1:0]  ord_base;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = advance && !q_empty;
   assign rec     = sgec_pkg::record_decode(head.mode, step_ff);
   assign is_last = step_ff == head.last_step;
   assign q_pop   = fire && is_last;

   // Step counter and output valid
   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         step_in      = is_last ? '0 : step_ff + 5'd1;
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Record assembly
   assign ord_base = rec.kind ? head.ord_vol : head.ord_surf;

   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in.last     = is_last;
      rsp_data_in.bad_cell = rec.bad;
      if (!rec.bad) begin
         rsp_data_in.kind    = rec.kind;
         rsp_data_in.ordinal = ord_base + {30'd0, rec.offset};
         rsp_data_in.node_a  = head.corner[rec.idx[0]];
         rsp_data_in.node_b  = head.corner[rec.idx[1]];
         rsp_data_in.node_c  = head.corner[rec.idx[2]];
         if (rec.use_d) rsp_data_in.node_d = head.corner[rec.idx[3]];
         if (rec.use_hi) begin
            rsp_data_in.node_e = head.corner[4];
            rsp_data_in.node_f = head.corner[5];
            rsp_data_in.node_g = head.corner[6];
            rsp_data_in.node_h = head.corner[7];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/structured_grid_element_connectivity_unit.sv]
// Top level of the structured grid connectivity block: registers, front, queue, back.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall sgec_pkg::req_type (cell_x, cell_y, cell_z)
//   rsp      out        rsp_valid/rsp_stall sgec_pkg::rsp_type (one record)
//   csr      in         csr_valid/csr_ready csr_index, csr_data
//
// One record leaves per cycle while rsp_stall is low; a cell yields 1 to 25 records
// (quad 1, triangles 2, hexahedron 1 or 7, tetrahedra 5 or 25),
// set by the back end's step counter.
// The front end is a four-stage pipeline (A to D); a cell then passes a queue slot and the back end's output register.
// Reset is synchronous, clears the pipeline and queue and sets the registers to their defaults; no clearing pass.
// A stalled output holds its record while the front keeps filling the four-entry queue.
module structured_grid_element_connectivity_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sgec_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sgec_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgec_pkg::CSR_DAT_W-1:0]       csr_data
);

   sgec_pkg::cfg_type   cfg_ff;
   sgec_pkg::entry_type push_entry, head;
   logic                q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nodes_x      <= 11'd2;
         cfg_ff.nodes_y      <= 11'd2;
         cfg_ff.nodes_z      <= 11'd1;
         cfg_ff.element_type <= sgec_pkg::ET_QUAD;
         cfg_ff.emit_faces   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sgec_pkg::CSR_NODES_X:      cfg_ff.nodes_x      <= csr_data;
            sgec_pkg::CSR_NODES_Y:      cfg_ff.nodes_y      <= csr_data;
            sgec_pkg::CSR_NODES_Z:      cfg_ff.nodes_z      <= csr_data;
            sgec_pkg::CSR_ELEMENT_TYPE: cfg_ff.element_type <= csr_data[2:0];
            sgec_pkg::CSR_EMIT_FACES:   cfg_ff.emit_faces   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   sgec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   sgec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   sgec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/structured_grid_element_connectivity_unit_test.sv]
// Self-checking testbench for the structured grid connectivity unit.
`timescale 1ns / 1ps

module structured_grid_element_connectivity_unit_test;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_CELLS = 420;
   localparam int CODE3_COUNT = 8;     // size of a 3-bit code space
   localparam int CIDX_MAX = (1 << sgec_pkg::CIDX_W) - 1;
   localparam int AXIS_MAX = (1 << sgec_pkg::AXIS_W) - 1;

   // Corner picks of the five tetrahedra, corners 0..3 bottom and 4..7 top
   localparam int TETRA_CORNERS [5][4] = '{
      '{0, 1, 3, 4}, '{1, 2, 3, 6}, '{4, 3, 7, 6}, '{4, 1, 6, 5}, '{3, 1, 4, 6}
   };
   // Sides of one tetrahedron: abc, abd, bcd, acd
   localparam int TETRA_FACES [4][3] = '{
      '{0, 1, 2}, '{0, 1, 3}, '{1, 2, 3}, '{0, 2, 3}
   };
   // Sides of a brick
   localparam int BRICK_FACES [6][4] = '{
      '{0, 1, 2, 3}, '{4, 5, 6, 7}, '{1, 5, 6, 2},
      '{0, 4, 7, 3}, '{0, 1, 5, 4}, '{3, 2, 6, 7}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   sgec_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   sgec_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [sgec_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sgec_pkg::CSR_DAT_W-1:0] csr_data = '0;

   // Register image as the block should hold it
   logic [sgec_pkg::AXIS_W-1:0] cfg_nodes_x = 11'd2;
   logic [sgec_pkg::AXIS_W-1:0] cfg_nodes_y = 11'd2;
   logic [sgec_pkg::AXIS_W-1:0] cfg_nodes_z = 11'd1;
   logic [2:0]                  cfg_element_type = sgec_pkg::ET_QUAD;
   logic                        cfg_emit_faces = 1'b1;

   sgec_pkg::req_type cells_to_send [$];
   sgec_pkg::rsp_type records_due [$];
   int      cells_queued = 0;
   int      cells_taken = 0;
   int      records_seen = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   logic    quiet_phase = 1'b0;
   logic    hold_arm = 1'b0;
   logic    hold_done = 1'b0;

   structured_grid_element_connectivity_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned axis_limit(input logic [sgec_pkg::AXIS_W-1:0] n);
      longint unsigned cap;
      cap = sgec_pkg::MAX_NODES_PER_AXIS;
      return (n > cap) ? cap : longint'(n);
   endfunction

   function automatic sgec_pkg::rsp_type node_record(input bit kind,
                                                     input longint unsigned ord,
                                                     input longint unsigned a, b, c, d,
                                                     input longint unsigned e, f, g, h);
      sgec_pkg::rsp_type r;
      r = '0;
      r.kind    = kind;
      r.ordinal = sgec_pkg::ORD_W'(ord);
      r.node_a  = sgec_pkg::NODE_W'(a);
      r.node_b  = sgec_pkg::NODE_W'(b);
      r.node_c  = sgec_pkg::NODE_W'(c);
      r.node_d  = sgec_pkg::NODE_W'(d);
      r.node_e  = sgec_pkg::NODE_W'(e);
      r.node_f  = sgec_pkg::NODE_W'(f);
      r.node_g  = sgec_pkg::NODE_W'(g);
      r.node_h  = sgec_pkg::NODE_W'(h);
      return r;
   endfunction

   // Expected connectivity records of one cell under the current registers
   function automatic void predict_cell_records(input sgec_pkg::req_type c);
      longint unsigned nx, ny, nz, x, y, z, nxy, cell_num, k0, base;
      longint unsigned v [8];
      sgec_pkg::rsp_type recs [$];
      sgec_pkg::rsp_type r;
      bit vol;
      bit bad;
      nx = axis_limit(cfg_nodes_x);
      ny = axis_limit(cfg_nodes_y);
      nz = axis_limit(cfg_nodes_z);
      x = c.cell_x;
      y = c.cell_y;
      z = c.cell_z;
      vol = (cfg_element_type == sgec_pkg::ET_TET) || (cfg_element_type == sgec_pkg::ET_HEX);
      bad = (cfg_element_type > sgec_pkg::ET_HEX);
      if (x < 1 || nx < 2 || x > nx - 1) bad = 1'b1;
      if (y < 1 || ny < 2 || y > ny - 1) bad = 1'b1;
      if (vol && (z < 1 || nz < 2 || z > nz - 1)) bad = 1'b1;
      if (!vol) z = 1;

      if (bad) begin
         r = '0;
         r.bad_cell = 1'b1;
         r.last = 1'b1;
         records_due.push_back(r);
         return;
      end

      nxy = nx * ny;
      cell_num = ((z - 1) * (ny - 1) + (y - 1)) * (nx - 1) + x;
      k0 = (z - 1) * nxy + (y - 1) * nx + x;
      v[0] = k0;
      v[1] = k0 + 1;
      v[2] = k0 + nx + 1;
      v[3] = k0 + nx;
      for (int i = 0; i < 4; i++) v[4 + i] = v[i] + nxy;

      case (cfg_element_type)
         sgec_pkg::ET_QUAD: begin
            recs.push_back(node_record(1'b0, cell_num, v[0], v[1], v[2], v[3], 0, 0, 0, 0));
         end
         sgec_pkg::ET_TRI_ALT, sgec_pkg::ET_TRI_UNI: begin
            // odd x+y (or uniform mode) cuts from second to fourth corner
            if (cfg_element_type == sgec_pkg::ET_TRI_UNI || ((x + y) & 1) == 1) begin
               recs.push_back(node_record(1'b0, 2 * cell_num - 1, v[0], v[1], v[3], 0,
                                          0, 0, 0, 0));
               recs.push_back(node_record(1'b0, 2 * cell_num, v[1], v[2], v[3], 0,
                                          0, 0, 0, 0));
            end else begin
               recs.push_back(node_record(1'b0, 2 * cell_num - 1, v[0], v[1], v[2], 0,
                                          0, 0, 0, 0));
               recs.push_back(node_record(1'b0, 2 * cell_num, v[0], v[2], v[3], 0,
                                          0, 0, 0, 0));
            end
         end
         sgec_pkg::ET_TET: begin
            base = 5 * (cell_num - 1);
            for (int i = 0; i < 5; i++)
               recs.push_back(node_record(1'b1, base + i + 1,
                                          v[TETRA_CORNERS[i][0]], v[TETRA_CORNERS[i][1]],
                                          v[TETRA_CORNERS[i][2]], v[TETRA_CORNERS[i][3]],
                                          0, 0, 0, 0));
            if (cfg_emit_faces) begin
               for (int i = 0; i < 5; i++)
                  for (int f = 0; f < 4; f++)
                     recs.push_back(node_record(1'b0, 4 * (base + i) + f + 1,
                                                v[TETRA_CORNERS[i][TETRA_FACES[f][0]]],
                                                v[TETRA_CORNERS[i][TETRA_FACES[f][1]]],
                                                v[TETRA_CORNERS[i][TETRA_FACES[f][2]]],
                                                0, 0, 0, 0, 0));
            end
         end
         default: begin
            recs.push_back(node_record(1'b1, cell_num, v[0], v[1], v[2], v[3],
                                       v[4], v[5], v[6], v[7]));
            if (cfg_emit_faces) begin
               for (int f = 0; f < 6; f++)
                  recs.push_back(node_record(1'b0, 6 * (cell_num - 1) + f + 1,
                                             v[BRICK_FACES[f][0]], v[BRICK_FACES[f][1]],
                                             v[BRICK_FACES[f][2]], v[BRICK_FACES[f][3]],
                                             0, 0, 0, 0));
            end
         end
      endcase
      recs[recs.size() - 1].last = 1'b1;
      foreach (recs[i]) records_due.push_back(recs[i]);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want, got);
      error_count++;
      $display("%0t: record %0d %0s: expected %0d, got %0d",
               $realtime, records_seen, what, want, got);
   endtask

   task automatic check_record(input sgec_pkg::rsp_type got);
      sgec_pkg::rsp_type want;
      records_seen++;
      if (records_due.size() == 0) begin
         report_mismatch("arrived with nothing due, ordinal", 0, got.ordinal);
         return;
      end
      want = records_due.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", want.kind, got.kind);
      if (got.ordinal !== want.ordinal) report_mismatch("ordinal", want.ordinal, got.ordinal);
      if (got.node_a !== want.node_a) report_mismatch("node_a", want.node_a, got.node_a);
      if (got.node_b !== want.node_b) report_mismatch("node_b", want.node_b, got.node_b);
      if (got.node_c !== want.node_c) report_mismatch("node_c", want.node_c, got.node_c);
      if (got.node_d !== want.node_d) report_mismatch("node_d", want.node_d, got.node_d);
      if (got.node_e !== want.node_e) report_mismatch("node_e", want.node_e, got.node_e);
      if (got.node_f !== want.node_f) report_mismatch("node_f", want.node_f, got.node_f);
      if (got.node_g !== want.node_g) report_mismatch("node_g", want.node_g, got.node_g);
      if (got.node_h !== want.node_h) report_mismatch("node_h", want.node_h, got.node_h);
      if (got.bad_cell !== want.bad_cell)
         report_mismatch("bad_cell", want.bad_cell, got.bad_cell);
      if (got.last !== want.last) report_mismatch("last", want.last, got.last);
   endtask

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap(input logic quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Item driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cell_records(req_data);
            cells_taken++;
         end
         if (req_valid && req_stall) begin
            // item still on offer, hold it
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (cells_to_send.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= cells_to_send.pop_front();
            gap_left <= pick_gap(quiet_phase);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Record monitor and output stall
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_record(rsp_data);
         if (hold_arm && !hold_done) begin
            // one long hold so the block backs up into its input
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
            stall_left <= HOLD_CYCLES;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            gap = pick_gap(quiet_phase);
            rsp_stall <= (gap > 0);
            stall_left <= (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [sgec_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sgec_pkg::CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         sgec_pkg::CSR_NODES_X:      cfg_nodes_x = value;
         sgec_pkg::CSR_NODES_Y:      cfg_nodes_y = value;
         sgec_pkg::CSR_NODES_Z:      cfg_nodes_z = value;
         sgec_pkg::CSR_ELEMENT_TYPE: cfg_element_type = value[2:0];
         sgec_pkg::CSR_EMIT_FACES:   cfg_emit_faces = value[0];
         default: ;
      endcase
   endtask

   task automatic queue_cell(input int x, input int y, input int z);
      sgec_pkg::req_type c;
      c.cell_x = sgec_pkg::CIDX_W'(x);
      c.cell_y = sgec_pkg::CIDX_W'(y);
      c.cell_z = sgec_pkg::CIDX_W'(z);
      cells_to_send.push_back(c);
      cells_queued++;
   endtask

   task automatic wait_drained();
      while (cells_taken != cells_queued || records_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [sgec_pkg::AXIS_W-1:0] random_axis();
      int roll;
      roll = $urandom_range(99);
      if (roll < 72) return sgec_pkg::AXIS_W'($urandom_range(2, 9));
      if (roll < 84) return sgec_pkg::AXIS_W'($urandom_range(10, 60));
      if (roll < 90) return sgec_pkg::AXIS_W'(sgec_pkg::MAX_NODES_PER_AXIS);
      if (roll < 94)
         return sgec_pkg::AXIS_W'($urandom_range(sgec_pkg::MAX_NODES_PER_AXIS + 1, AXIS_MAX));
      if (roll < 97) return sgec_pkg::AXIS_W'($urandom_range(1));
      return sgec_pkg::AXIS_W'($urandom_range(61, sgec_pkg::MAX_NODES_PER_AXIS - 1));
   endfunction

   // Mostly a cell inside the grid, sometimes any index at all
   function automatic int random_index(input longint unsigned n);
      if (n >= 2 && $urandom_range(99) < 94) return $urandom_range(1, int'(n) - 1);
      return $urandom_range(CIDX_MAX);
   endfunction

   initial begin
      int         phase_len;
      int         random_sent;
      bit         first_phase;
      logic [2:0] et;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset grid: single quad, each axis just out of range, z ignored
      queue_cell(1, 1, 1);
      queue_cell(0, 1, 1);
      queue_cell(2, 1, 1);
      queue_cell(1, 0, 1);
      queue_cell(1, 2, 1);
      queue_cell(1, 1, CIDX_MAX);
      wait_drained();

      // largest planar grid, alternating diagonal on both parities
      write_reg(sgec_pkg::CSR_NODES_X, sgec_pkg::AXIS_W'(sgec_pkg::MAX_NODES_PER_AXIS));
      write_reg(sgec_pkg::CSR_NODES_Y, sgec_pkg::AXIS_W'(sgec_pkg::MAX_NODES_PER_AXIS));
      write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(sgec_pkg::ET_TRI_ALT));
      queue_cell(1, 1, 1);
      queue_cell(2, 1, 7);
      queue_cell(CIDX_MAX, CIDX_MAX, 0);
      queue_cell(CIDX_MAX - 1, CIDX_MAX, 1);
      wait_drained();

      write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(sgec_pkg::ET_TRI_UNI));
      queue_cell(1, 1, 1);
      queue_cell(CIDX_MAX, CIDX_MAX, 1);
      wait_drained();

      // tetrahedra with faces, corner cells and a zero layer
      write_reg(sgec_pkg::CSR_NODES_Z, sgec_pkg::AXIS_W'(sgec_pkg::MAX_NODES_PER_AXIS));
      write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(sgec_pkg::ET_TET));
      queue_cell(1, 1, 1);
      queue_cell(CIDX_MAX, CIDX_MAX, CIDX_MAX);
      queue_cell(1, 1, 0);
      wait_drained();

      // upper data bits set, only bit 0 counts
      write_reg(sgec_pkg::CSR_EMIT_FACES, {{(sgec_pkg::CSR_DAT_W - 1){1'b1}}, 1'b0});
      queue_cell(2, 3, 4);
      wait_drained();

      write_reg(sgec_pkg::CSR_ELEMENT_TYPE, {8'hff, sgec_pkg::ET_HEX});
      queue_cell(1, 1, 1);
      wait_drained();
      write_reg(sgec_pkg::CSR_EMIT_FACES, sgec_pkg::CSR_DAT_W'(1));
      queue_cell(CIDX_MAX, CIDX_MAX, CIDX_MAX);
      queue_cell(5, 5, 0);
      wait_drained();

      // unknown element types reject every cell
      for (int i = int'(sgec_pkg::ET_HEX) + 1; i < CODE3_COUNT; i++) begin
         write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(i));
         queue_cell(1, 1, 1);
         wait_drained();
      end

      // oversized count clamps, writes past the last register do nothing
      write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(sgec_pkg::ET_QUAD));
      write_reg(sgec_pkg::CSR_NODES_X, sgec_pkg::AXIS_W'(AXIS_MAX));
      for (int i = int'(sgec_pkg::CSR_EMIT_FACES) + 1; i < CODE3_COUNT; i++)
         write_reg(sgec_pkg::CSR_IDX_W'(i), '1);
      queue_cell(CIDX_MAX, 1, 1);
      wait_drained();
      // too few nodes leaves no cells
      write_reg(sgec_pkg::CSR_NODES_X, sgec_pkg::AXIS_W'(1));
      queue_cell(1, 1, 1);
      wait_drained();
      write_reg(sgec_pkg::CSR_NODES_X, sgec_pkg::AXIS_W'(0));
      queue_cell(1, 1, 1);
      wait_drained();

      // random phases, each with fresh registers
      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_CELLS) begin
         if (first_phase) begin
            write_reg(sgec_pkg::CSR_NODES_X, sgec_pkg::AXIS_W'(6));
            write_reg(sgec_pkg::CSR_NODES_Y, sgec_pkg::AXIS_W'(5));
            write_reg(sgec_pkg::CSR_NODES_Z, sgec_pkg::AXIS_W'(4));
            write_reg(sgec_pkg::CSR_ELEMENT_TYPE, sgec_pkg::CSR_DAT_W'(sgec_pkg::ET_TET));
            write_reg(sgec_pkg::CSR_EMIT_FACES, sgec_pkg::CSR_DAT_W'(1));
            phase_len = 40;
         end else begin
            write_reg(sgec_pkg::CSR_NODES_X, random_axis());
            write_reg(sgec_pkg::CSR_NODES_Y, random_axis());
            write_reg(sgec_pkg::CSR_NODES_Z, random_axis());
            if ($urandom_range(99) < 8)
               et = 3'($urandom_range(int'(sgec_pkg::ET_HEX) + 1, CODE3_COUNT - 1));
            else
               et = 3'($urandom_range(int'(sgec_pkg::ET_HEX)));
            write_reg(sgec_pkg::CSR_ELEMENT_TYPE, {8'($urandom()), et});
            write_reg(sgec_pkg::CSR_EMIT_FACES, sgec_pkg::CSR_DAT_W'($urandom()));
            phase_len = $urandom_range(20, 50);
         end
         quiet_phase <= !first_phase && ($urandom_range(3) == 0);
         if (first_phase) hold_arm <= 1'b1;
         for (int k = 0; k < phase_len; k++) begin
            queue_cell(random_index(axis_limit(cfg_nodes_x)),
                       random_index(axis_limit(cfg_nodes_y)),
                       random_index(axis_limit(cfg_nodes_z)));
            random_sent++;
         end
         wait_drained();
         first_phase = 1'b0;
      end

      // settle; any record that arrives meanwhile counts as unexpected
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
